/* src/pli_pkg.sv */
`default_nettype none

package pli_pkg;

    // Operation codes of a request.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // Configuration register indexes.
    localparam logic [2:0] CFG_TIME_STEP      = 3'd0;
    localparam logic [2:0] CFG_POSITION_SCALE = 3'd1;
    localparam logic [2:0] CFG_LOWER_X        = 3'd2;
    localparam logic [2:0] CFG_UPPER_X        = 3'd3;
    localparam logic [2:0] CFG_LOWER_Y        = 3'd4;
    localparam logic [2:0] CFG_UPPER_Y        = 3'd5;
    localparam logic [2:0] CFG_LOWER_Z        = 3'd6;
    localparam logic [2:0] CFG_UPPER_Z        = 3'd7;

    localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

    // Quotient bits retired per divider cycle.
    localparam int DIV_BITS  = 2;
    localparam int DIV_STEPS = 32 / DIV_BITS;
    localparam int DIV_CW    = $clog2(DIV_STEPS);

    typedef struct packed {
        logic               op;
        logic [7:0]         slot;
        logic signed [31:0] load_pos_x;
        logic signed [31:0] load_pos_y;
        logic signed [31:0] load_pos_z;
        logic signed [31:0] load_vel_x;
        logic signed [31:0] load_vel_y;
        logic signed [31:0] load_vel_z;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic [31:0]        load_mass;
    } t_in_req;

    typedef struct packed {
        logic [7:0]         out_slot;
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] new_pos_z;
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic signed [31:0] new_vel_z;
        logic               still_active;
    } t_out_res;

    // Three axes, index 0 is x.
    typedef logic [2:0][31:0] t_vec3;

    // One particle table entry.
    typedef struct packed {
        logic        act;
        logic [31:0] mass;
        t_vec3       acc;
        t_vec3       vel;
        t_vec3       pos;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Divider status toward the sequencer.
    typedef struct packed {
        logic        done;
        logic        ovf;
        logic [31:0] quot;
    } t_div_stat;

    // Signed result from a magnitude; ovf means the magnitude is at least 2^32.
    function automatic logic [31:0] sat_mag(input logic neg, input logic ovf,
                                            input logic [31:0] q);
        logic [31:0] res;
        if (neg) begin
            res = (ovf || q[31]) ? SAT_MIN : (32'd0 - q);
        end else begin
            res = (ovf || q[31]) ? SAT_MAX : q;
        end
        return res;
    endfunction

    // Clamp a 34-bit signed sum to 32 bits.
    function automatic logic [31:0] sat34(input logic signed [33:0] x);
        logic [31:0] res;
        if (x > 34'sh0_7FFF_FFFF) begin
            res = SAT_MAX;
        end else if (x < -34'sh0_8000_0000) begin
            res = SAT_MIN;
        end else begin
            res = x[31:0];
        end
        return res;
    endfunction

    // Magnitude of a signed 32-bit value.
    function automatic logic [31:0] mag32(input logic [31:0] x);
        return x[31] ? (32'd0 - x) : x;
    endfunction

endpackage

`default_nettype wire

/* src/pli_ram.sv */
`default_nettype none

module pli_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Single port, read before write, registered read data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

/* src/pli_div.sv */
`default_nettype none

module pli_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [63:0]       i_dividend,
    input  wire logic [32:0]       i_divisor,
    output pli_pkg::t_div_stat     o_stat
);

    import pli_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic              r_ovf;
    logic [32:0]       r_rem;
    logic [31:0]       r_q;
    logic [32:0]       r_dvsr;
    logic [DIV_CW-1:0] r_cnt;

    logic [32:0] step_rem;
    logic [31:0] step_q;

    // Restoring division, DIV_BITS quotient bits per cycle.
    always_comb begin
        logic [33:0] trial;
        step_rem = r_rem;
        step_q   = r_q;
        for (int b = 0; b < DIV_BITS; b++) begin
            trial = {step_rem, step_q[31]};
            step_q = {step_q[30:0], 1'b0};
            if (trial >= {1'b0, r_dvsr}) begin
                trial     = trial - {1'b0, r_dvsr};
                step_q[0] = 1'b1;
            end
            step_rem = trial[32:0];
        end
    end

    // The quotient overflows 32 bits exactly when the upper dividend half
    // is not below the divisor; otherwise 32 quotient bits remain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ovf  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_dvsr <= i_divisor;
                r_cnt  <= '0;
                r_rem  <= {1'b0, i_dividend[63:32]};
                r_q    <= i_dividend[31:0];
                if ({1'b0, i_dividend[63:32]} >= i_divisor) begin
                    r_ovf  <= 1'b1;
                    r_done <= 1'b1;
                end else begin
                    r_ovf  <= 1'b0;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem <= step_rem;
                r_q   <= step_q;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CW'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat = '{done: r_done, ovf: r_ovf, quot: r_q};

    // A finished division does not report while iterations remain.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while busy");

    // The last iteration always reports completion next cycle.
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_start && r_cnt == DIV_CW'(DIV_STEPS - 1)) |=> r_done)
        else $error("divider missed completion");

    // An overflowed division ends at once.
    a_ovf_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_ovf) |-> $past(i_start))
        else $error("overflow reported late");

endmodule

`default_nettype wire

/* src/particle_leapfrog_integrator.sv */
`default_nettype none

// Particle table with one velocity-Verlet step per step request, signed Q16.16.
// For a step request on an enabled particle, each of the three axes runs up to
// three divisions (velocity term by scale, acceleration term by twice the scale,
// force by mass, skipped for zero mass) on one shared divider that retires two
// quotient bits a cycle, plus four passes through one shared 33x32 multiplier.
// One request is in work at a time; o_in_stall is high until its result is in
// the output register, which holds it while i_out_stall is high. After reset a
// clearing pass writes every table entry once before the first request is taken.
// Slots at or beyond PARTICLE_SLOTS report zeros with still_active low.
module particle_leapfrog_integrator #(
    parameter int PARTICLE_SLOTS = 256
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire pli_pkg::t_in_req  i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output pli_pkg::t_out_res      o_out_data,
    input  wire logic              i_cfg_we,
    input  wire logic [2:0]        i_cfg_index,
    input  wire logic [31:0]       i_cfg_data
);

    import pli_pkg::*;

    localparam int          AW      = $clog2(PARTICLE_SLOTS);
    localparam logic [16:0] SLOTS_W = 17'(PARTICLE_SLOTS);

    typedef enum logic [16:0] {
        S_CLEAR  = 17'h00001,
        S_IDLE   = 17'h00002,
        S_READ   = 17'h00004,
        S_DECIDE = 17'h00008,
        S_MULV   = 17'h00010,
        S_T1GO   = 17'h00020,
        S_T1W    = 17'h00040,
        S_MULA   = 17'h00080,
        S_MULH   = 17'h00100,
        S_T2GO   = 17'h00200,
        S_T2W    = 17'h00400,
        S_A1GO   = 17'h00800,
        S_A1W    = 17'h01000,
        S_MULS   = 17'h02000,
        S_UPD    = 17'h04000,
        S_WRITE  = 17'h08000,
        S_DONE   = 17'h10000
    } t_state;

    t_state      r_state;
    logic [AW-1:0] r_clr;
    t_in_req     r_req;
    t_entry      r_entry;
    logic [1:0]  r_k;
    logic [64:0] r_prod;
    logic [31:0] r_t1;
    logic [31:0] r_t2;
    logic [31:0] r_a1;
    logic        r_ovalid;
    t_out_res    r_out;

    logic [31:0] r_dt;
    logic [31:0] r_scale;
    t_vec3       r_lo;
    t_vec3       r_hi;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt    <= 32'd655;
            r_scale <= 32'd65536;
            r_lo    <= {3{SAT_MIN}};
            r_hi    <= {3{SAT_MAX}};
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TIME_STEP:      r_dt     <= i_cfg_data;
                CFG_POSITION_SCALE: r_scale  <= i_cfg_data;
                CFG_LOWER_X:        r_lo[0]  <= i_cfg_data;
                CFG_UPPER_X:        r_hi[0]  <= i_cfg_data;
                CFG_LOWER_Y:        r_lo[1]  <= i_cfg_data;
                CFG_UPPER_Y:        r_hi[1]  <= i_cfg_data;
                CFG_LOWER_Z:        r_lo[2]  <= i_cfg_data;
                CFG_UPPER_Z:        r_hi[2]  <= i_cfg_data;
                default:            r_dt     <= r_dt;
            endcase
        end
    end

    logic [31:0] scale_eff;
    assign scale_eff = (r_scale == 32'd0) ? 32'd1 : r_scale;

    // Particle table.
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    t_entry        ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    t_entry        rd_entry;

    assign ram_we    = (r_state == S_CLEAR) || (r_state == S_WRITE);
    assign ram_addr  = (r_state == S_CLEAR) ? r_clr : AW'(r_req.slot);
    assign ram_wdata = (r_state == S_CLEAR) ? t_entry'('0) : r_entry;
    assign rd_entry  = t_entry'(ram_rdata);

    pli_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (PARTICLE_SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // Operands of the axis in work.
    logic [31:0] ax_p, ax_v, ax_a0, ax_f;
    logic [31:0] v_mag, a0_mag, f_mag;
    logic [32:0] asum;
    logic [32:0] asum_mag;
    logic [31:0] h_cap;

    assign ax_p  = r_entry.pos[r_k];
    assign ax_v  = r_entry.vel[r_k];
    assign ax_a0 = r_entry.acc[r_k];

    always_comb begin
        case (r_k)
            2'd0:    ax_f = r_req.force_x;
            2'd1:    ax_f = r_req.force_y;
            default: ax_f = r_req.force_z;
        endcase
    end

    assign v_mag    = mag32(ax_v);
    assign a0_mag   = mag32(ax_a0);
    assign f_mag    = mag32(ax_f);
    assign asum     = {ax_a0[31], ax_a0} + {r_a1[31], r_a1};
    assign asum_mag = asum[32] ? (33'd0 - asum) : asum;
    assign h_cap    = (|r_prod[64:48]) ? 32'hFFFF_FFFF : r_prod[47:16];

    // Shared multiplier operand.
    logic [32:0] mul_a;
    always_comb begin
        case (r_state)
            S_MULV:  mul_a = {1'b0, v_mag};
            S_MULA:  mul_a = {1'b0, a0_mag};
            S_MULH:  mul_a = {1'b0, h_cap};
            default: mul_a = asum_mag;
        endcase
    end

    // Shared divider.
    logic        div_start;
    logic [63:0] div_dividend;
    logic [32:0] div_divisor;
    t_div_stat   div_stat;

    always_comb begin
        div_start    = 1'b0;
        div_dividend = r_prod[63:0];
        div_divisor  = {1'b0, scale_eff};
        case (r_state)
            S_T1GO: begin
                div_start = 1'b1;
            end
            S_T2GO: begin
                div_start   = 1'b1;
                div_divisor = {scale_eff, 1'b0};
            end
            S_A1GO: begin
                div_start    = (r_entry.mass != 32'd0);
                div_dividend = {16'd0, f_mag, 16'd0};
                div_divisor  = {1'b0, r_entry.mass};
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    pli_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_stat     (div_stat)
    );

    // Axis update from the finished terms.
    logic [31:0] dv, np, nv;
    logic        outside;
    assign dv = sat_mag(asum_mag[32] ^ asum_mag[32] ^ asum[32], |r_prod[64:49],
                        r_prod[48:17]);
    assign np = sat34({{2{ax_p[31]}}, ax_p} + {{2{r_t1[31]}}, r_t1}
                      + {{2{r_t2[31]}}, r_t2});
    assign nv = sat34({{2{ax_v[31]}}, ax_v} + {{2{dv[31]}}, dv});
    assign outside = ($signed(np) > $signed(r_hi[r_k]))
                  || ($signed(np) < $signed(r_lo[r_k]));

    logic in_range;
    logic out_take;
    assign in_range = {9'd0, r_req.slot} < SLOTS_W;
    assign out_take = r_ovalid && !i_out_stall;

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // In the result state a taken result is replaced by the next one.
            if (out_take && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(PARTICLE_SLOTS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_req   <= i_in_data;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    r_k <= 2'd0;
                    if (!in_range) begin
                        r_entry <= '0;
                        r_state <= S_DONE;
                    end else if (r_req.op == OP_LOAD) begin
                        r_entry.act  <= 1'b1;
                        r_entry.mass <= r_req.load_mass;
                        r_entry.pos  <= {r_req.load_pos_z, r_req.load_pos_y, r_req.load_pos_x};
                        r_entry.vel  <= {r_req.load_vel_z, r_req.load_vel_y, r_req.load_vel_x};
                        r_entry.acc  <= {r_req.force_z, r_req.force_y, r_req.force_x};
                        r_state      <= S_WRITE;
                    end else begin
                        r_entry <= rd_entry;
                        r_state <= rd_entry.act ? S_MULV : S_DONE;
                    end
                end
                S_MULV: begin
                    r_prod  <= 65'(mul_a) * 65'(r_dt);
                    r_state <= S_T1GO;
                end
                S_T1GO: begin
                    r_state <= S_T1W;
                end
                S_T1W: begin
                    if (div_stat.done) begin
                        r_t1    <= sat_mag(ax_v[31], div_stat.ovf, div_stat.quot);
                        r_state <= S_MULA;
                    end
                end
                S_MULA: begin
                    r_prod  <= 65'(mul_a) * 65'(r_dt);
                    r_state <= S_MULH;
                end
                S_MULH: begin
                    r_prod  <= 65'(mul_a) * 65'(r_dt);
                    r_state <= S_T2GO;
                end
                S_T2GO: begin
                    r_state <= S_T2W;
                end
                S_T2W: begin
                    if (div_stat.done) begin
                        r_t2    <= sat_mag(ax_a0[31], div_stat.ovf, div_stat.quot);
                        r_state <= S_A1GO;
                    end
                end
                S_A1GO: begin
                    if (r_entry.mass == 32'd0) begin
                        // Zero mass saturates by the sign of the force.
                        if (ax_f == 32'd0) begin
                            r_a1 <= 32'd0;
                        end else begin
                            r_a1 <= ax_f[31] ? SAT_MIN : SAT_MAX;
                        end
                        r_state <= S_MULS;
                    end else begin
                        r_state <= S_A1W;
                    end
                end
                S_A1W: begin
                    if (div_stat.done) begin
                        r_a1    <= sat_mag(ax_f[31], div_stat.ovf, div_stat.quot);
                        r_state <= S_MULS;
                    end
                end
                S_MULS: begin
                    r_prod  <= 65'(mul_a) * 65'(r_dt);
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_entry.pos[r_k] <= np;
                    r_entry.vel[r_k] <= nv;
                    r_entry.acc[r_k] <= r_a1;
                    if (outside) begin
                        r_entry.act <= 1'b0;
                    end
                    if (r_k == 2'd2) begin
                        r_state <= S_WRITE;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_MULV;
                    end
                end
                S_WRITE: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ovalid || out_take) begin
                        r_ovalid <= 1'b1;
                        r_out    <= '{out_slot:     r_req.slot,
                                      new_pos_x:    r_entry.pos[0],
                                      new_pos_y:    r_entry.pos[1],
                                      new_pos_z:    r_entry.pos[2],
                                      new_vel_x:    r_entry.vel[0],
                                      new_vel_y:    r_entry.vel[1],
                                      new_vel_z:    r_entry.vel[2],
                                      still_active: r_entry.act};
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    // An accepted request always starts with the table read.
    a_accept_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_READ))
        else $error("request not followed by table read");

    // The last axis update always writes the entry back.
    a_last_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD && r_k == 2'd2) |=> (r_state == S_WRITE))
        else $error("entry not written after last axis");

    // A new result appears only from the result state.
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_DONE))
        else $error("result raised outside result state");

    // The divider reports only while the sequencer waits for it.
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == S_T1W || r_state == S_T2W || r_state == S_A1W))
        else $error("divider result with nobody waiting");

endmodule

`default_nettype wire

/* test/tb_particle_leapfrog_integrator.sv */
`timescale 1ns / 100ps

module tb_particle_leapfrog_integrator;
    import pli_pkg::*;

    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -64'sd2147483648;
    localparam int DRAIN_CYCLES = 400;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_req     i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_res    o_out_data;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = CFG_TIME_STEP;
    logic [31:0] i_cfg_data = '0;

    particle_leapfrog_integrator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the particle table and the configuration.
    longint     pos_tbl [256][3];
    longint     vel_tbl [256][3];
    longint     acc_tbl [256][3];
    bit [63:0]  mass_tbl [256];
    bit         act_tbl [256];
    bit         loaded [256];
    bit [63:0]  dt_reg;
    bit [63:0]  scale_reg;
    longint     box_lo [3];
    longint     box_hi [3];

    t_out_res   expected_states [$];
    int         mismatches = 0;
    int         burst_left = 0;
    bit         steady_sender = 1'b0;
    int         stall_pct = 30;
    int         hold_cycles = 0;

    // Saturate a sign and magnitude to Q16.16.
    function automatic longint sat_signed(bit neg, bit [63:0] m);
        if (neg) begin
            return (m >= 64'h8000_0000) ? Q_MIN : -longint'(m);
        end
        return (m > 64'h7FFF_FFFF) ? Q_MAX : longint'(m);
    endfunction

    function automatic bit [63:0] magnitude(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint clamp_q(longint v);
        return (v > Q_MAX) ? Q_MAX : ((v < Q_MIN) ? Q_MIN : v);
    endfunction

    function automatic longint force_to_accel(longint f, bit [63:0] m);
        if (m == 0) begin
            return (f > 0) ? Q_MAX : ((f < 0) ? Q_MIN : 64'sd0);
        end
        return sat_signed(f < 0, (magnitude(f) << 16) / m);
    endfunction

    // Apply one request to the shadow table and return the entry it reports.
    function automatic t_out_res integrate_particle(t_in_req r);
        t_out_res  res;
        int        s;
        int        k;
        longint    f [3];
        longint    p;
        longint    v;
        longint    a0;
        longint    a1;
        longint    t1;
        longint    t2;
        longint    asum;
        longint    np;
        bit [63:0] h;
        bit [63:0] sc;
        bit        outside;
        s = int'(r.slot);
        f[0] = longint'(r.force_x);
        f[1] = longint'(r.force_y);
        f[2] = longint'(r.force_z);
        if (r.op == OP_LOAD) begin
            pos_tbl[s][0] = longint'(r.load_pos_x);
            pos_tbl[s][1] = longint'(r.load_pos_y);
            pos_tbl[s][2] = longint'(r.load_pos_z);
            vel_tbl[s][0] = longint'(r.load_vel_x);
            vel_tbl[s][1] = longint'(r.load_vel_y);
            vel_tbl[s][2] = longint'(r.load_vel_z);
            for (k = 0; k < 3; k++) acc_tbl[s][k] = f[k];
            mass_tbl[s] = 64'(r.load_mass);
            act_tbl[s] = 1'b1;
            loaded[s] = 1'b1;
        end else if (act_tbl[s]) begin
            outside = 1'b0;
            sc = (scale_reg == 0) ? 64'd1 : scale_reg;
            for (k = 0; k < 3; k++) begin
                p = pos_tbl[s][k];
                v = vel_tbl[s][k];
                a0 = acc_tbl[s][k];
                a1 = force_to_accel(f[k], mass_tbl[s]);
                t1 = sat_signed(v < 0, (magnitude(v) * dt_reg) / sc);
                h = (magnitude(a0) * dt_reg) >> 16;
                if (h > 64'hFFFF_FFFF) h = 64'hFFFF_FFFF;
                t2 = sat_signed(a0 < 0, (h * dt_reg) / (2 * sc));
                np = clamp_q(p + t1 + t2);
                asum = a0 + a1;
                vel_tbl[s][k] = clamp_q(v + sat_signed(asum < 0,
                                        (magnitude(asum) * dt_reg) >> 17));
                pos_tbl[s][k] = np;
                acc_tbl[s][k] = a1;
                if (np > box_hi[k] || np < box_lo[k]) outside = 1'b1;
            end
            if (outside) act_tbl[s] = 1'b0;
        end
        res.out_slot = r.slot;
        res.new_pos_x = pos_tbl[s][0][31:0];
        res.new_pos_y = pos_tbl[s][1][31:0];
        res.new_pos_z = pos_tbl[s][2][31:0];
        res.new_vel_x = vel_tbl[s][0][31:0];
        res.new_vel_y = vel_tbl[s][1][31:0];
        res.new_vel_z = vel_tbl[s][2][31:0];
        res.still_active = act_tbl[s];
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h, expected %h", what, got, want);
        mismatches++;
    endtask

    // Compare each accepted result with the oldest expected entry state.
    always @(posedge i_clk) begin
        t_out_res want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_states.size() == 0) begin
                report_mismatch("unexpected result, slot", 32'(o_out_data.out_slot), '0);
            end else begin
                want = expected_states.pop_front();
                if (o_out_data.out_slot !== want.out_slot)
                    report_mismatch("out_slot", 32'(o_out_data.out_slot),
                                    32'(want.out_slot));
                if (o_out_data.new_pos_x !== want.new_pos_x)
                    report_mismatch("new_pos_x", o_out_data.new_pos_x, want.new_pos_x);
                if (o_out_data.new_pos_y !== want.new_pos_y)
                    report_mismatch("new_pos_y", o_out_data.new_pos_y, want.new_pos_y);
                if (o_out_data.new_pos_z !== want.new_pos_z)
                    report_mismatch("new_pos_z", o_out_data.new_pos_z, want.new_pos_z);
                if (o_out_data.new_vel_x !== want.new_vel_x)
                    report_mismatch("new_vel_x", o_out_data.new_vel_x, want.new_vel_x);
                if (o_out_data.new_vel_y !== want.new_vel_y)
                    report_mismatch("new_vel_y", o_out_data.new_vel_y, want.new_vel_y);
                if (o_out_data.new_vel_z !== want.new_vel_z)
                    report_mismatch("new_vel_z", o_out_data.new_vel_z, want.new_vel_z);
                if (o_out_data.still_active !== want.still_active)
                    report_mismatch("still_active", 32'(o_out_data.still_active),
                                    32'(want.still_active));
            end
        end
    end

    // Receiver stall pattern, with an occasional long hold-off.
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Send one request and record the entry state it should report.
    task automatic send_request(t_in_req r);
        int gap;
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in_data = r;
        do @(posedge i_clk); while (o_in_stall);
        expected_states.push_back(integrate_particle(r));
        if (!steady_sender) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap = ($urandom_range(9) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 6);
                if (gap > 0) begin
                    @(negedge i_clk);
                    i_in_valid = 1'b0;
                    repeat (gap - 1) @(negedge i_clk);
                end
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_states.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    task automatic write_register(logic [2:0] idx, logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_TIME_STEP:      dt_reg = 64'(value);
            CFG_POSITION_SCALE: scale_reg = 64'(value);
            CFG_LOWER_X:        box_lo[0] = longint'($signed(value));
            CFG_UPPER_X:        box_hi[0] = longint'($signed(value));
            CFG_LOWER_Y:        box_lo[1] = longint'($signed(value));
            CFG_UPPER_Y:        box_hi[1] = longint'($signed(value));
            CFG_LOWER_Z:        box_lo[2] = longint'($signed(value));
            default:            box_hi[2] = longint'($signed(value));
        endcase
    endtask

    task automatic set_box(logic [31:0] lo, logic [31:0] hi);
        write_register(CFG_LOWER_X, lo);
        write_register(CFG_UPPER_X, hi);
        write_register(CFG_LOWER_Y, lo);
        write_register(CFG_UPPER_Y, hi);
        write_register(CFG_LOWER_Z, lo);
        write_register(CFG_UPPER_Z, hi);
    endtask

    // Q16.16 value: mostly moderate, sometimes extreme or fully random.
    function automatic logic [31:0] random_q();
        case ($urandom_range(9))
            0: return $urandom();
            1: return SAT_MAX;
            2: return SAT_MIN;
            3: return '0;
            default: return 32'($signed($urandom_range(0, 32'h00C0_0000)) - 32'sh0060_0000);
        endcase
    endfunction

    function automatic logic [31:0] random_mass();
        case ($urandom_range(7))
            0: return '0;
            1: return $urandom();
            2: return 32'h0001_0000;
            default: return $urandom_range(32'h0000_4000, 32'h0008_0000);
        endcase
    endfunction

    function automatic t_in_req make_load(int s, logic [31:0] p, logic [31:0] v,
                                          logic [31:0] a, logic [31:0] m);
        t_in_req r;
        r.op = OP_LOAD;
        r.slot = 8'(s);
        r.load_pos_x = p;
        r.load_pos_y = p;
        r.load_pos_z = p;
        r.load_vel_x = v;
        r.load_vel_y = v;
        r.load_vel_z = v;
        r.force_x = a;
        r.force_y = a;
        r.force_z = a;
        r.load_mass = m;
        return r;
    endfunction

    function automatic t_in_req make_step(int s, logic [31:0] fx, logic [31:0] fy,
                                          logic [31:0] fz);
        t_in_req r;
        r = t_in_req'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                       $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                       $urandom()});
        r.op = OP_STEP;
        r.slot = 8'(s);
        r.force_x = fx;
        r.force_y = fy;
        r.force_z = fz;
        return r;
    endfunction

    // A load or a step on a slot that has been loaded; loads fill random slots.
    function automatic t_in_req random_request();
        t_in_req r;
        int s;
        s = ($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(15);
        if (!loaded[s] || $urandom_range(9) == 0) begin
            r = make_step(s, random_q(), random_q(), random_q());
            r.op = OP_LOAD;
            r.load_pos_x = random_q();
            r.load_pos_y = random_q();
            r.load_pos_z = random_q();
            r.load_vel_x = random_q();
            r.load_vel_y = random_q();
            r.load_vel_z = random_q();
            r.load_mass = random_mass();
        end else begin
            r = make_step(s, random_q(), random_q(), random_q());
        end
        return r;
    endfunction

    task automatic test_directed();
        send_request(make_load(0, '0, 32'h0001_0000, '0, 32'h0001_0000));
        send_request(make_step(0, 32'h0001_0000, 32'hFFFF_0000, '0));
        send_request(make_step(0, '0, '0, '0));
        // Zero mass with positive, negative and zero force, from extreme values.
        send_request(make_load(255, SAT_MAX, SAT_MAX, SAT_MAX, '0));
        send_request(make_step(255, SAT_MAX, SAT_MIN, '0));
        send_request(make_step(255, 32'h0000_0001, 32'hFFFF_FFFF, '0));
        send_request(make_load(1, SAT_MIN, SAT_MIN, SAT_MIN, 32'hFFFF_FFFF));
        send_request(make_step(1, SAT_MIN, SAT_MAX, 32'h1234_5678));
        wait_for_results();
        // A load outside the box still enables; the next step disables.
        set_box(32'hFFFF_0000, 32'h0001_0000);
        send_request(make_load(2, 32'h0005_0000, 32'h0001_0000, '0, 32'h0001_0000));
        send_request(make_step(2, '0, '0, '0));
        send_request(make_step(2, 32'h0001_0000, '0, '0));
        send_request(make_load(3, '0, '0, '0, 32'h0001_0000));
        send_request(make_step(3, '0, '0, '0));
        wait_for_results();
        // Zero scale acts as the smallest unit, together with the largest step.
        write_register(CFG_POSITION_SCALE, '0);
        write_register(CFG_TIME_STEP, 32'hFFFF_FFFF);
        set_box(SAT_MIN, SAT_MAX);
        send_request(make_load(4, '0, 32'h0000_0003, 32'hFFFF_FFFD, 32'h0002_0000));
        send_request(make_step(4, 32'h0000_0010, '0, 32'hFFFF_FFF0));
        send_request(make_step(0, 32'h0001_0000, '0, '0));
        wait_for_results();
    endtask

    task automatic test_config_phases();
        int phase;
        int n;
        for (phase = 0; phase < 6; phase++) begin
            wait_for_results();
            case (phase)
                0: begin
                    write_register(CFG_TIME_STEP, 32'd655);
                    write_register(CFG_POSITION_SCALE, 32'h0001_0000);
                    set_box(SAT_MIN, SAT_MAX);
                end
                1: begin
                    write_register(CFG_TIME_STEP, 32'h0000_4000);
                    set_box(32'hFF9C_0000, 32'h0064_0000);
                end
                2: begin
                    write_register(CFG_TIME_STEP, '0);
                    write_register(CFG_POSITION_SCALE, 32'h0000_0001);
                end
                3: begin
                    write_register(CFG_TIME_STEP, 32'hFFFF_FFFF);
                    write_register(CFG_POSITION_SCALE, 32'hFFFF_FFFF);
                    set_box(SAT_MIN, SAT_MAX);
                end
                4: begin
                    write_register(CFG_TIME_STEP, $urandom_range(32'h0002_0000));
                    write_register(CFG_POSITION_SCALE, $urandom());
                    write_register(CFG_LOWER_X, $urandom());
                    write_register(CFG_UPPER_X, $urandom());
                    write_register(CFG_LOWER_Y, 32'hFFF0_0000);
                    write_register(CFG_UPPER_Y, 32'h0010_0000);
                    write_register(CFG_LOWER_Z, 32'hFFE0_0000);
                    write_register(CFG_UPPER_Z, 32'h0020_0000);
                end
                default: begin
                    write_register(CFG_TIME_STEP, 32'd655);
                    write_register(CFG_POSITION_SCALE, 32'h0001_0000);
                    set_box(32'hFC00_0000, 32'h0400_0000);
                end
            endcase
            stall_pct = (phase == 5) ? 0 : $urandom_range(10, 60);
            steady_sender = (phase == 2);
            for (n = 0; n < 240; n++) send_request(random_request());
        end
        steady_sender = 1'b0;
        wait_for_results();
    endtask

    // Hold the receiver off while requests keep coming, so the input stalls.
    task automatic test_backpressure();
        int n;
        @(posedge i_clk);
        hold_cycles = 600;
        steady_sender = 1'b1;
        for (n = 0; n < 60; n++) send_request(random_request());
        steady_sender = 1'b0;
        wait_for_results();
    endtask

    initial begin
        dt_reg = 64'd655;
        scale_reg = 64'h1_0000;
        for (int k = 0; k < 3; k++) begin
            box_lo[k] = Q_MIN;
            box_hi[k] = Q_MAX;
        end
        for (int i = 0; i < 256; i++) begin
            act_tbl[i] = 1'b0;
            loaded[i] = 1'b0;
        end
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_config_phases();
        test_backpressure();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("FAILURE");
        $finish;
    end

endmodule

/* sim.f */
src/pli_pkg.sv
src/pli_ram.sv
src/pli_div.sv
src/particle_leapfrog_integrator.sv
test/tb_particle_leapfrog_integrator.sv
